FILE: rtl/fir_convolution_1d_core_macros.svh
// ----------------------------------------------------------------------------
// FIR convolution core assertion macros
// Concurrent assertion shorthands used by the port checker file.
// ----------------------------------------------------------------------------
`ifndef FIR_CONVOLUTION_1D_CORE_MACROS_SVH
`define FIR_CONVOLUTION_1D_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define FCV_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define FCV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fcv_pkg.sv
// ----------------------------------------------------------------------------
// FIR convolution package
// Widths, payload types, wave control struct and feeder states.
// ----------------------------------------------------------------------------
package fcv_pkg;

   // Default number of taps in the cell row
   localparam int TAPS_DEFAULT = 16;

   // Q1.15 samples and coefficients, Q6.30 sums
   localparam int SMP_W = 16;
   localparam int SUM_W = 36;

   typedef logic signed [SMP_W-1:0] fcv_smp_type;
   typedef logic signed [SUM_W-1:0] fcv_sum_type;

   // Control that travels with each wave through the tap row
   typedef struct packed {
      logic vld;       // wave carries an item
      logic is_smp;    // 1: signal sample or tail zero, 0: coefficient load
      logic wr;        // load position lies inside the row
      logic clr;       // clear history once this wave has passed
      logic emit;      // wave yields a result at the end of the row
      logic last_res;  // final result of the signal
   } fcv_ctl_type;

   // Feeder states
   typedef enum logic {
      FCV_RUN,
      FCV_TAIL
   } fcv_state_type;

endpackage

FILE: rtl/fcv_if.sv
// ----------------------------------------------------------------------------
// FIR convolution channel interfaces
// Valid/ready channels for input items, results and the control register.
// ----------------------------------------------------------------------------
interface fcv_req_if;
   import fcv_pkg::*;

   logic        valid;
   logic        ready;
   logic        mode;
   fcv_smp_type sample_value;
   logic        last;

   modport source (output valid, output mode, output sample_value, output last,
                   input ready);
   modport sink   (input valid, input mode, input sample_value, input last,
                   output ready);
endinterface

interface fcv_rsp_if;
   import fcv_pkg::*;

   logic        valid;
   logic        ready;
   fcv_sum_type conv_value;
   logic        last_res;

   modport source (output valid, output conv_value, output last_res, input ready);
   modport sink   (input valid, input conv_value, input last_res, output ready);
endinterface

interface fcv_csr_if;
   logic valid;
   logic ready;
   logic delay_correct;

   modport source (output valid, output delay_correct, input ready);
   modport sink   (input valid, input delay_correct, output ready);
endinterface

FILE: rtl/fcv_feeder.sv
// ----------------------------------------------------------------------------
// FIR convolution feeder
// Takes input items, tracks kernel length, load position and dropped
// outputs, and launches one wave per cycle into the tap row while it
// advances, including the zero tail after the final sample of a signal.
// ----------------------------------------------------------------------------
module fcv_feeder #(
   parameter int TAPS = fcv_pkg::TAPS_DEFAULT,
   parameter int KW   = $clog2(TAPS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   fcv_req_if.sink             req_bus,
   fcv_csr_if.sink             csr_bus,
   output fcv_pkg::fcv_ctl_type ctl_o,
   output logic [KW-1:0]       tag_o,
   output fcv_pkg::fcv_smp_type smp_o
);
   import fcv_pkg::*;

   localparam int SW = $clog2(TAPS / 2 + 2);

   fcv_state_type state_ff, state_in;
   logic [KW-1:0] load_pos_ff, load_pos_in;
   logic [KW-1:0] klen_ff, klen_in;
   logic [SW-1:0] sup_ff, sup_in;
   logic [KW-1:0] tail_ff, tail_in;
   logic          dc_ff;
   logic          xfer;
   logic          wr;
   logic          drop;
   logic          end_sig;

   // Control register: always ready
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         dc_ff <= csr_bus.delay_correct;
      end
   end

   // Take input only while running and the row can advance
   assign req_bus.ready = adv && (state_ff == FCV_RUN);
   assign xfer          = req_bus.valid && req_bus.ready;

   // Hold feeder state while the row is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FCV_RUN;
         load_pos_ff <= '0;
         klen_ff     <= '0;
         sup_ff      <= '0;
         tail_ff     <= '0;
      end else if (adv) begin
         state_ff    <= state_in;
         load_pos_ff <= load_pos_in;
         klen_ff     <= klen_in;
         sup_ff      <= sup_in;
         tail_ff     <= tail_in;
      end
   end

   assign wr      = load_pos_ff < KW'(TAPS);
   assign drop    = dc_ff && (KW'(sup_ff) < (klen_ff >> 1));
   assign end_sig = dc_ff || (klen_ff == KW'(1));

   // Next state and wave launch
   always_comb begin
      state_in    = state_ff;
      load_pos_in = load_pos_ff;
      klen_in     = klen_ff;
      sup_in      = sup_ff;
      tail_in     = tail_ff;
      ctl_o       = '0;
      tag_o       = klen_ff;
      smp_o       = req_bus.sample_value;

      unique case (state_ff)
         FCV_RUN: begin
            if (xfer && !req_bus.mode) begin
               // Coefficient load: write through the row, close on last
               ctl_o.vld = 1'b1;
               ctl_o.wr  = wr;
               tag_o     = load_pos_ff;
               if (wr) begin
                  load_pos_in = load_pos_ff + KW'(1);
               end
               if (req_bus.last) begin
                  ctl_o.clr   = 1'b1;
                  klen_in     = wr ? load_pos_ff + KW'(1) : load_pos_ff;
                  load_pos_in = '0;
                  sup_in      = '0;
               end
            end else if (xfer && (klen_ff != '0)) begin
               // Signal sample: drop leading outputs under delay correction
               ctl_o.vld      = 1'b1;
               ctl_o.is_smp   = 1'b1;
               ctl_o.emit     = !drop;
               ctl_o.last_res = req_bus.last && end_sig;
               ctl_o.clr      = req_bus.last && end_sig;
               if (drop) begin
                  sup_in = sup_ff + SW'(1);
               end
               if (req_bus.last) begin
                  sup_in = '0;
                  if (!end_sig) begin
                     state_in = FCV_TAIL;
                     tail_in  = KW'(1);
                  end
               end
            end
         end
         FCV_TAIL: begin
            // Flush the kernel with zero samples
            ctl_o.vld      = 1'b1;
            ctl_o.is_smp   = 1'b1;
            ctl_o.emit     = 1'b1;
            ctl_o.last_res = tail_ff == klen_ff - KW'(1);
            ctl_o.clr      = ctl_o.last_res;
            smp_o          = '0;
            tail_in        = tail_ff + KW'(1);
            if (ctl_o.last_res) begin
               state_in = FCV_RUN;
            end
         end
         default: begin
            state_in = FCV_RUN;
         end
      endcase
   end

endmodule

FILE: rtl/fcv_tap_cell.sv
// ----------------------------------------------------------------------------
// FIR convolution tap cell
// One tap: holds a coefficient and one history sample, adds its product to
// the passing partial sum and hands the older sample to its neighbour.
// ----------------------------------------------------------------------------
module fcv_tap_cell #(
   parameter int TAPS = fcv_pkg::TAPS_DEFAULT,
   parameter int KW   = $clog2(TAPS + 1),
   parameter int IDX  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  fcv_pkg::fcv_ctl_type ctl_i,
   input  logic [KW-1:0]        tag_i,
   input  fcv_pkg::fcv_smp_type smp_i,
   input  fcv_pkg::fcv_sum_type psum_i,
   output fcv_pkg::fcv_ctl_type ctl_o,
   output logic [KW-1:0]        tag_o,
   output fcv_pkg::fcv_smp_type smp_o,
   output fcv_pkg::fcv_sum_type psum_o
);
   import fcv_pkg::*;

   fcv_smp_type               coef_ff;
   fcv_smp_type               hist_ff;
   fcv_ctl_type               ctl_ff;
   logic [KW-1:0]             tag_ff;
   fcv_smp_type               smp_ff, smp_in;
   fcv_sum_type               psum_ff, psum_in;
   logic signed [2*SMP_W-1:0] prod;
   logic                      active;
   logic                      coef_we;

   // Multiply-add on the passing wave; taps past the kernel add nothing
   assign prod    = coef_ff * smp_i;
   assign active  = ctl_i.is_smp && (KW'(IDX) < tag_i);
   assign psum_in = psum_i + (active ? SUM_W'(prod) : '0);
   assign smp_in  = ctl_i.is_smp ? hist_ff : smp_i;
   assign coef_we = ctl_i.vld && !ctl_i.is_smp && ctl_i.wr && (tag_i == KW'(IDX));

   // Coefficient store, written only by a load aimed at this tap
   always_ff @(posedge clock) begin
      if (adv && coef_we) begin
         coef_ff <= smp_i;
      end
   end

   // Shift history on samples, clear at the end of a signal
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (adv && ctl_i.vld) begin
         if (ctl_i.clr) begin
            hist_ff <= '0;
         end else if (ctl_i.is_smp) begin
            hist_ff <= smp_i;
         end
      end
   end

   // Advance the wave to the next tap
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_ff  <= tag_i;
         smp_ff  <= smp_in;
         psum_ff <= psum_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign tag_o  = tag_ff;
   assign smp_o  = smp_ff;
   assign psum_o = psum_ff;

endmodule

FILE: rtl/fir_convolution_1d_core.sv
// ----------------------------------------------------------------------------
// FIR convolution core
// Streaming direct-form FIR giving the full linear convolution of a sample
// stream with a loaded kernel, built as a row of TAPS multiply-add cells.
// ----------------------------------------------------------------------------
// Items travel through a row of TAPS cells, one cell each time the row
// advances, each cell doing one 16x16 multiply and one 36-bit add; a
// result passes the TAPS cell registers and then the output register. One
// item is taken per cycle while the result side keeps up; a stalled result
// stalls the whole row and the input. After the final sample of a signal
// with delay correction off, the input is held while the K-1 zero samples
// of the tail are fed into the row. Loads and samples may be mixed freely;
// a load lands in its cell in item order. Results are exact Q6.30 sums,
// wrapping to 36 bits above 31 taps. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module fir_convolution_1d_core #(
   parameter int TAPS = fcv_pkg::TAPS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   fcv_req_if.sink    req_bus,
   fcv_rsp_if.source  rsp_bus,
   fcv_csr_if.sink    csr_bus
);
   import fcv_pkg::*;

   localparam int KW = $clog2(TAPS + 1);

   fcv_ctl_type   ctl  [TAPS+1];
   logic [KW-1:0] tag  [TAPS+1];
   fcv_smp_type   smp  [TAPS+1];
   fcv_sum_type   psum [TAPS+1];
   logic          adv;
   logic          rsp_valid_ff;
   fcv_sum_type   conv_ff;
   logic          last_ff;

   // Row advances whenever the output register is free or being taken
   assign adv = !rsp_valid_ff || rsp_bus.ready;

   fcv_feeder #(
      .TAPS (TAPS),
      .KW   (KW)
   ) u_feeder (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .ctl_o   (ctl[0]),
      .tag_o   (tag[0]),
      .smp_o   (smp[0])
   );

   assign psum[0] = '0;

   // Tap row
   for (genvar g = 0; g < TAPS; g++) begin : g_tap
      fcv_tap_cell #(
         .TAPS (TAPS),
         .KW   (KW),
         .IDX  (g)
      ) u_tap (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .ctl_i  (ctl[g]),
         .tag_i  (tag[g]),
         .smp_i  (smp[g]),
         .psum_i (psum[g]),
         .ctl_o  (ctl[g+1]),
         .tag_o  (tag[g+1]),
         .smp_o  (smp[g+1]),
         .psum_o (psum[g+1])
      );
   end

   // Output register: capture waves that carry a result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl[TAPS].vld && ctl[TAPS].emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         conv_ff <= psum[TAPS];
         last_ff <= ctl[TAPS].last_res;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.conv_value = conv_ff;
   assign rsp_bus.last_res   = last_ff;

endmodule

FILE: rtl/fcv_port_check.sv
// ----------------------------------------------------------------------------
// FIR convolution port checks
// Watches the top level ports for output holding and stall behaviour.
// ----------------------------------------------------------------------------
`include "fir_convolution_1d_core_macros.svh"

module fcv_port_check (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fcv_pkg::fcv_sum_type conv_value,
   input logic                 last_res
);
   import fcv_pkg::*;

   // Stalled result stays offered
   `FCV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
                    "result dropped while stalled")

   // Stalled result keeps its payload
   `FCV_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
                    $stable(conv_value) && $stable(last_res),
                    "result payload changed while stalled")

   // A stalled output stalls the input side too
   `FCV_ASSERT_SAME(a_stall_back, clock, reset, rsp_valid && !rsp_ready, !req_ready,
                    "input taken while output stalled")

   // Nothing offered right after reset
   `FCV_ASSERT_SAME(a_reset_empty, clock, reset, $past(reset), !rsp_valid,
                    "result offered straight after reset")

endmodule

bind fir_convolution_1d_core fcv_port_check u_fcv_port_check (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .conv_value (rsp_bus.conv_value),
   .last_res   (rsp_bus.last_res)
);

FILE: dv/tb_fir_convolution_1d_core.sv
// ----------------------------------------------------------------------------
// FIR convolution core testbench
// Drives coefficient loads and signal samples into the core and checks every
// result, field by field and in order, against a predictor of the full
// convolution, including delay correction, the zero tail and partial reloads.
// A directed table opens the run; random kernels and signals follow under
// three idle patterns, with a long result stall and drains between phases.
// ----------------------------------------------------------------------------
module tb_fir_convolution_1d_core;
   import fcv_pkg::*;

   localparam int TAPS        = TAPS_DEFAULT;
   localparam int SETTLE      = TAPS + 8;
   localparam int HOLD_CYCLES = 120;
   localparam int STALL_LIMIT = 2000;
   localparam int DIR_ROWS    = 27;
   localparam int PHASE_ITEMS = 54;
   localparam int MAX_REPORTS = 50;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      ROW_LOAD,
      ROW_SAMPLE,
      ROW_CSR
   } row_kind_type;

   // One row of the directed table; pinned rows carry a typed expectation
   typedef struct packed {
      row_kind_type kind;
      fcv_smp_type  value;
      logic         last;
      logic         pin;
      logic         pin_has;
      fcv_sum_type  pin_conv;
      logic         pin_last;
   } dir_row_type;

   typedef struct packed {
      fcv_sum_type conv;
      logic        last;
   } conv_out_type;

   logic clock = 1'b0;
   logic reset;

   fcv_req_if req_ch ();
   fcv_rsp_if rsp_ch ();
   fcv_csr_if csr_ch ();

   fir_convolution_1d_core #(.TAPS(TAPS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   always #2 clock = ~clock;

   // Predictor state
   fcv_smp_type coef_mem [TAPS];
   fcv_smp_type hist_mem [TAPS-1];
   int          load_pos;
   int          kern_len;
   int          drop_cnt;
   logic        dly_corr;

   conv_out_type fresh_outputs [$];
   conv_out_type expected_outputs [$];
   conv_out_type want;

   // Typed expectation for the item currently offered
   logic        pin_on;
   logic        pin_has;
   fcv_sum_type pin_conv;
   logic        pin_last;

   int snd_idle_pct;
   int rcv_idle_pct;
   int hold_seq;
   int errors;
   int items_taken;
   int results_seen;
   int kernels_done;
   int signals_done;

   dir_row_type plan [DIR_ROWS];

   task automatic report_mismatch(input string what);
      if (errors < MAX_REPORTS)
         $display("MISMATCH at %0t: %s", $time, what);
      errors++;
   endtask

   // Shift one sample into the tap line and return the exact Q6.30 sum
   function automatic fcv_sum_type shift_in(fcv_smp_type x);
      longint acc;
      int     m;
      acc = longint'(x) * longint'(coef_mem[0]);
      for (m = 1; m < kern_len; m++)
         acc += longint'(hist_mem[m-1]) * longint'(coef_mem[m]);
      for (m = kern_len - 1; m > 1; m--)
         hist_mem[m-1] = hist_mem[m-2];
      if (kern_len > 1)
         hist_mem[0] = x;
      return acc[SUM_W-1:0];
   endfunction

   function automatic void end_signal();
      foreach (hist_mem[i])
         hist_mem[i] = '0;
      drop_cnt = 0;
   endfunction

   // Work out the results of one transfer into fresh_outputs
   function automatic void convolve_item(logic m, fcv_smp_type v, logic l);
      fcv_sum_type y;
      logic        drop;
      int          t;
      if (m == MODE_LOAD) begin
         if (load_pos < TAPS) begin
            coef_mem[load_pos] = v;
            load_pos++;
         end
         if (l) begin
            kern_len = load_pos;
            load_pos = 0;
            kernels_done++;
            end_signal();
         end
         return;
      end
      if (kern_len == 0)
         return;
      y = shift_in(v);
      drop = dly_corr && (drop_cnt < kern_len / 2);
      if (drop)
         drop_cnt++;
      else
         fresh_outputs.push_back('{y, l && (dly_corr || kern_len == 1)});
      if (l) begin
         if (!dly_corr) begin
            for (t = 1; t < kern_len; t++)
               fresh_outputs.push_back('{shift_in('0), t == kern_len - 1});
         end
         signals_done++;
         end_signal();
      end
   endfunction

   // Track transfers on all three channels and check results in order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            dly_corr = csr_ch.delay_correct;
         if (req_ch.valid && req_ch.ready) begin
            items_taken++;
            fresh_outputs.delete();
            convolve_item(req_ch.mode, req_ch.sample_value, req_ch.last);
            if (pin_on) begin
               if (pin_has)
                  expected_outputs.push_back('{pin_conv, pin_last});
            end else begin
               foreach (fresh_outputs[i])
                  expected_outputs.push_back(fresh_outputs[i]);
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (expected_outputs.size() == 0) begin
               report_mismatch($sformatf("unexpected result conv_value %0d last_res %0b",
                                         rsp_ch.conv_value, rsp_ch.last_res));
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_ch.conv_value !== want.conv)
                  report_mismatch($sformatf("conv_value %0d, expected %0d",
                                            rsp_ch.conv_value, want.conv));
               if (rsp_ch.last_res !== want.last)
                  report_mismatch($sformatf("last_res %0b, expected %0b",
                                            rsp_ch.last_res, want.last));
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int hold_left;
      int hold_taken;
      hold_left = 0;
      hold_taken = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_taken) begin
            hold_taken = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // End the run when nothing has been transferred for too long
   initial begin : watchdog
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            stall = 0;
         else
            stall++;
      end
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // Offer one item from a falling edge and hold it until the transfer
   task automatic send_item(input logic m, input fcv_smp_type v, input logic l);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= m;
      req_ch.sample_value <= v;
      req_ch.last         <= l;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid, wait for every expected result, then let the row empty
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_outputs.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_delay_correct(input logic dc);
      csr_ch.valid         <= 1'b1;
      csr_ch.delay_correct <= dc;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic fcv_smp_type pick_value(bit extreme);
      if (extreme)
         return 16'sh8000;
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return fcv_smp_type'($urandom);
      endcase
   endfunction

   // Mostly whole kernels and signals, with some noise and broken loads
   task automatic feed_random(input int quota);
      int stop_at;
      int k;
      int len;
      int roll;
      int i;
      bit extreme;
      stop_at = items_taken + quota;
      while (items_taken < stop_at) begin
         roll = $urandom_range(99);
         extreme = ($urandom_range(7) == 0);
         if (roll < 75) begin
            // optional fresh kernel, sometimes longer than the row
            if (extreme || $urandom_range(2) == 0) begin
               if (extreme)
                  k = TAPS;
               else if ($urandom_range(9) == 0)
                  k = $urandom_range(TAPS + 4, TAPS + 1);
               else
                  k = $urandom_range(TAPS, 1);
               for (i = 0; i < k; i++)
                  send_item(MODE_LOAD, pick_value(extreme), i == k - 1);
            end
            len = extreme ? TAPS + 2 : $urandom_range(20, 1);
            for (i = 0; i < len && items_taken < stop_at; i++)
               send_item(MODE_SAMPLE, pick_value(extreme), i == len - 1);
         end else if (roll < 88) begin
            send_item(logic'($urandom_range(1)), pick_value(0), $urandom_range(3) == 0);
         end else begin
            // reload left open with samples in between
            k = $urandom_range(4, 1);
            for (i = 0; i < k; i++)
               send_item(MODE_LOAD, pick_value(0), 1'b0);
            len = $urandom_range(3, 1);
            for (i = 0; i < len; i++)
               send_item(MODE_SAMPLE, pick_value(0), 1'b0);
         end
      end
   endtask

   initial begin : stimulus
      int r;
      int dcv;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_LOAD;
      req_ch.sample_value = '0;
      req_ch.last = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.delay_correct = 1'b0;
      pin_on = 1'b0;
      pin_has = 1'b0;
      pin_conv = '0;
      pin_last = 1'b0;
      snd_idle_pct = 27;
      rcv_idle_pct = 55;
      hold_seq = 0;
      errors = 0;
      items_taken = 0;
      results_seen = 0;
      kernels_done = 0;
      signals_done = 0;
      foreach (coef_mem[i])
         coef_mem[i] = '0;
      foreach (hist_mem[i])
         hist_mem[i] = '0;
      load_pos = 0;
      kern_len = 0;
      drop_cnt = 0;
      dly_corr = 1'b0;

      plan = '{
         '{ROW_CSR,    16'sh0000, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         // sample with no kernel gives nothing
         '{ROW_SAMPLE, 16'sh1234, 1'b0, 1'b1, 1'b0, 36'sd0, 1'b0},
         // single tap, largest and smallest products
         '{ROW_LOAD,   16'sh7FFF, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh7FFF, 1'b0, 1'b1, 1'b1, 36'sd1073676289, 1'b0},
         '{ROW_SAMPLE, 16'sh8000, 1'b0, 1'b1, 1'b1, -36'sd1073709056, 1'b0},
         '{ROW_SAMPLE, 16'sh0000, 1'b1, 1'b1, 1'b1, 36'sd0, 1'b1},
         '{ROW_LOAD,   16'sh8000, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh8000, 1'b1, 1'b1, 1'b1, 36'sd1073741824, 1'b1},
         // three taps with a zero tail
         '{ROW_LOAD,   16'sh0001, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_LOAD,   16'sh0002, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_LOAD,   16'sh0003, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0001, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'shFFFF, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         // sample in the middle of a reload
         '{ROW_LOAD,   16'sh0100, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0005, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_LOAD,   16'sh0200, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh7FFF, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         // delay correction: leading drop, then a signal that is all dropped
         '{ROW_CSR,    16'sh0001, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0003, 1'b0, 1'b1, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0004, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0007, 1'b1, 1'b1, 1'b0, 36'sd0, 1'b0},
         '{ROW_LOAD,   16'sh0010, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_LOAD,   16'sh0020, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_LOAD,   16'sh0030, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0001, 1'b0, 1'b1, 1'b0, 36'sd0, 1'b0},
         // switch correction off in the middle of the signal
         '{ROW_CSR,    16'sh0000, 1'b0, 1'b0, 1'b0, 36'sd0, 1'b0},
         '{ROW_SAMPLE, 16'sh0002, 1'b1, 1'b0, 1'b0, 36'sd0, 1'b0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_idle();
            write_delay_correct(plan[i].value[0]);
         end else begin
            pin_on   = plan[i].pin;
            pin_has  = plan[i].pin_has;
            pin_conv = plan[i].pin_conv;
            pin_last = plan[i].pin_last;
            send_item(plan[i].kind == ROW_LOAD ? MODE_LOAD : MODE_SAMPLE,
                      plan[i].value, plan[i].last);
         end
      end
      pin_on = 1'b0;
      wait_idle();

      // Random phases: three idle patterns, correction on then off in each
      for (r = 0; r < 3; r++) begin
         snd_idle_pct = (r == 0) ? 27 : (r == 1) ? 55 : 0;
         rcv_idle_pct = (r == 0) ? 55 : (r == 1) ? 27 : 0;
         for (dcv = 1; dcv >= 0; dcv--) begin
            write_delay_correct(logic'(dcv));
            // long result stall while items keep coming
            if (r == 2 && dcv == 1)
               hold_seq++;
            feed_random(PHASE_ITEMS);
            wait_idle();
         end
      end

      $display("Run covered %0d items, %0d completed kernel loads, %0d signals and %0d results",
               items_taken, kernels_done, signals_done, results_seen);
      $display("with delay correction on and off, idling on both sides and a long result stall");
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", errors);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
